// ===== rtl/flca_pkg.sv =====
package flca_pkg;

   localparam int NODE_W = 8;
   localparam int CNT_W = 7;
   localparam int OP_W = 3;
   localparam int STEP_W = 4;
   localparam int NODE_COUNT = 256;
   localparam logic [CNT_W-1:0] MAX_ALLOC = CNT_W'(64);

   localparam logic [OP_W-1:0] OP_ALLOC = 3'd0;
   localparam logic [OP_W-1:0] OP_WLINK = 3'd1;
   localparam logic [OP_W-1:0] OP_WCHILD = 3'd2;
   localparam logic [OP_W-1:0] OP_SETFREE = 3'd3;
   localparam logic [OP_W-1:0] OP_READ = 3'd4;

   localparam logic [STEP_W-1:0] S_CLR = 4'd0;
   localparam logic [STEP_W-1:0] S_IDLE = 4'd1;
   localparam logic [STEP_W-1:0] S_A0 = 4'd2;
   localparam logic [STEP_W-1:0] S_A1 = 4'd3;
   localparam logic [STEP_W-1:0] S_A2 = 4'd4;
   localparam logic [STEP_W-1:0] S_A3 = 4'd5;
   localparam logic [STEP_W-1:0] S_EMPTY = 4'd6;
   localparam logic [STEP_W-1:0] S_R0 = 4'd7;
   localparam logic [STEP_W-1:0] S_R1 = 4'd8;
   localparam logic [STEP_W-1:0] S_WL = 4'd9;
   localparam logic [STEP_W-1:0] S_WC = 4'd10;
   localparam logic [STEP_W-1:0] S_FH = 4'd11;

   localparam logic [2:0] C_SEQ = 3'd0;
   localparam logic [2:0] C_GO = 3'd1;
   localparam logic [2:0] C_REQ = 3'd2;
   localparam logic [2:0] C_HEAD0 = 3'd3;
   localparam logic [2:0] C_EMIT = 3'd4;
   localparam logic [2:0] C_CLR = 3'd5;

   localparam logic [1:0] RA_NODE = 2'd0;
   localparam logic [1:0] RA_SEL = 2'd1;
   localparam logic [1:0] RA_WALK = 2'd2;

   localparam logic [1:0] LW_NONE = 2'd0;
   localparam logic [1:0] LW_VAL = 2'd1;
   localparam logic [1:0] LW_TAIL = 2'd2;
   localparam logic [1:0] LW_CLR = 2'd3;

   localparam logic [1:0] CW_NONE = 2'd0;
   localparam logic [1:0] CW_VAL = 2'd1;
   localparam logic [1:0] CW_PARENT = 2'd2;
   localparam logic [1:0] CW_CLR = 2'd3;

   localparam logic [1:0] FH_NONE = 2'd0;
   localparam logic [1:0] FH_VAL = 2'd1;
   localparam logic [1:0] FH_WALK = 2'd2;

   localparam logic [1:0] EM_NONE = 2'd0;
   localparam logic [1:0] EM_ALLOC = 2'd1;
   localparam logic [1:0] EM_EMPTY = 2'd2;
   localparam logic [1:0] EM_READ = 2'd3;

   typedef struct packed {
      logic [2:0] cond;
      logic [STEP_W-1:0] target;
      logic take;
      logic load_node;
      logic [1:0] raddr;
      logic [1:0] link_we;
      logic [1:0] child_we;
      logic [1:0] fh;
      logic [1:0] emit;
   } ctl_type;

   typedef struct packed {
      logic req_valid;
      logic [OP_W-1:0] opcode;
      logic head_zero;
      logic emit_fire;
      logic emit_last;
      logic clr_last;
   } stat_type;

   function automatic ctl_type ucode(input logic [STEP_W-1:0] step);
      ctl_type w;
      w = '0;
      w.cond = C_GO;
      w.target = S_IDLE;
      w.raddr = RA_NODE;
      w.link_we = LW_NONE;
      w.child_we = CW_NONE;
      w.fh = FH_NONE;
      w.emit = EM_NONE;
      unique case (step)
         S_CLR: begin
            w.cond = C_CLR;
            w.link_we = LW_CLR;
            w.child_we = CW_CLR;
         end
         S_IDLE: begin
            w.cond = C_REQ;
            w.take = 1'b1;
         end
         S_A0: begin
            w.cond = C_HEAD0;
            w.target = S_EMPTY;
            w.load_node = 1'b1;
         end
         S_A1: begin
            w.cond = C_SEQ;
         end
         S_A2: begin
            w.cond = C_EMIT;
            w.target = S_A3;
            w.raddr = RA_WALK;
            w.fh = FH_WALK;
            w.emit = EM_ALLOC;
         end
         S_A3: begin
            w.link_we = LW_TAIL;
            w.child_we = CW_PARENT;
         end
         S_EMPTY: begin
            w.cond = C_EMIT;
            w.emit = EM_EMPTY;
         end
         S_R0: begin
            w.cond = C_SEQ;
            w.raddr = RA_SEL;
         end
         S_R1: begin
            w.cond = C_EMIT;
            w.raddr = RA_SEL;
            w.emit = EM_READ;
         end
         S_WL: begin
            w.link_we = LW_VAL;
         end
         S_WC: begin
            w.child_we = CW_VAL;
         end
         S_FH: begin
            w.fh = FH_VAL;
         end
         default: begin
            w.cond = C_GO;
         end
      endcase
      return w;
   endfunction

   function automatic logic [STEP_W-1:0] op_entry(input logic [OP_W-1:0] op);
      logic [STEP_W-1:0] s;
      s = S_IDLE;
      unique case (op)
         OP_ALLOC: s = S_A0;
         OP_WLINK: s = S_WL;
         OP_WCHILD: s = S_WC;
         OP_SETFREE: s = S_FH;
         OP_READ: s = S_R0;
         default: s = S_IDLE;
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/flca_ram.sv =====
module flca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic clock,
   input  logic we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/flca_seq.sv =====
module flca_seq (
   input  logic clock,
   input  logic reset,
   input  flca_pkg::stat_type stat,
   output flca_pkg::ctl_type ctl
);

   logic [flca_pkg::STEP_W-1:0] upc_ff;
   logic [flca_pkg::STEP_W-1:0] upc_in;

   assign ctl = flca_pkg::ucode(upc_ff);

   always_comb begin
      upc_in = upc_ff;
      case (ctl.cond)
         flca_pkg::C_SEQ: upc_in = upc_ff + flca_pkg::STEP_W'(1);
         flca_pkg::C_GO: upc_in = ctl.target;
         flca_pkg::C_REQ: begin
            if (stat.req_valid) begin
               upc_in = flca_pkg::op_entry(stat.opcode);
            end
         end
         flca_pkg::C_HEAD0: begin
            upc_in = stat.head_zero ? ctl.target : upc_ff + flca_pkg::STEP_W'(1);
         end
         flca_pkg::C_EMIT: begin
            if (stat.emit_fire && stat.emit_last) begin
               upc_in = ctl.target;
            end
         end
         flca_pkg::C_CLR: begin
            if (stat.clr_last) begin
               upc_in = ctl.target;
            end
         end
         default: upc_in = flca_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= flca_pkg::S_CLR;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// ===== rtl/free_list_chain_allocator_unit.sv =====
// write and set-free-head items each act in their own microcode step; a read passes steps R0 and R1 to its result
// allocate: steps A0 and A1 lead to the first result, then one result per cycle unless rsp_stall holds the output;
// step A3 links the tail; an allocate on an empty chain goes from A0 to the EMPTY step and gives a single result
// an allocate occupies the unit until its tail is linked; the unit takes one item at a time
// reset: synchronous; a clearing pass then zeroes both node memories,
// during which req_stall stays high
module free_list_chain_allocator_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [2:0] req_opcode,
   input  logic [7:0] req_node_sel,
   input  logic [7:0] req_write_value,
   input  logic [6:0] req_alloc_count,
   input  logic req_pause,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [7:0] rsp_node_index,
   output logic [6:0] rsp_taken_so_far,
   output logic rsp_empty_res,
   output logic rsp_last,
   output logic [7:0] rsp_read_link,
   output logic [7:0] rsp_read_child
);

   localparam int NW = flca_pkg::NODE_W;
   localparam int CW = flca_pkg::CNT_W;

   flca_pkg::ctl_type ctl;
   flca_pkg::stat_type stat;

   logic [NW-1:0] free_head_ff, free_head_in;
   logic [NW-1:0] node_ff, node_in;
   logic [NW-1:0] head_ff, head_in;
   logic [CW-1:0] taken_ff, taken_in;
   logic [CW-1:0] count_ff, count_in;
   logic [NW-1:0] sel_ff, sel_in;
   logic [NW-1:0] val_ff, val_in;
   logic pause_ff, pause_in;
   logic [NW-1:0] clr_ff, clr_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [NW-1:0] rsp_node_ff, rsp_node_in;
   logic [CW-1:0] rsp_taken_ff, rsp_taken_in;
   logic rsp_empty_ff, rsp_empty_in;
   logic rsp_last_ff, rsp_last_in;
   logic [NW-1:0] rsp_rlink_ff, rsp_rlink_in;
   logic [NW-1:0] rsp_rchild_ff, rsp_rchild_in;

   logic req_accept;
   logic out_free;
   logic emit_fire;
   logic emit_last;
   logic advance;

   logic link_we;
   logic [NW-1:0] link_waddr, link_wdata, link_raddr, link_rd;
   logic child_we;
   logic [NW-1:0] child_waddr, child_wdata, child_rd;

   flca_seq u_seq (
      .clock(clock),
      .reset(reset),
      .stat(stat),
      .ctl(ctl)
   );

   flca_ram #(.WIDTH(NW), .DEPTH(flca_pkg::NODE_COUNT)) u_link_ram (
      .clock(clock),
      .we(link_we),
      .waddr(link_waddr),
      .wdata(link_wdata),
      .raddr(link_raddr),
      .rdata(link_rd)
   );

   flca_ram #(.WIDTH(NW), .DEPTH(flca_pkg::NODE_COUNT)) u_child_ram (
      .clock(clock),
      .we(child_we),
      .waddr(child_waddr),
      .wdata(child_wdata),
      .raddr(sel_ff),
      .rdata(child_rd)
   );

   assign req_stall = !ctl.take;
   assign req_accept = req_valid && ctl.take;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit_fire = (ctl.emit != flca_pkg::EM_NONE) && out_free;
   assign emit_last = (ctl.emit != flca_pkg::EM_ALLOC) || (taken_ff == count_ff)
                      || (link_rd == '0);
   assign advance = (ctl.emit == flca_pkg::EM_ALLOC) && emit_fire && !emit_last;

   assign stat.req_valid = req_valid;
   assign stat.opcode = req_opcode;
   assign stat.head_zero = (free_head_ff == '0);
   assign stat.emit_fire = emit_fire;
   assign stat.emit_last = emit_last;
   assign stat.clr_last = &clr_ff;

   // memory ports
   always_comb begin
      case (ctl.raddr)
         flca_pkg::RA_SEL: link_raddr = sel_ff;
         flca_pkg::RA_WALK: link_raddr = advance ? link_rd : node_ff;
         default: link_raddr = node_ff;
      endcase

      link_we = 1'b0;
      link_waddr = node_ff;
      link_wdata = '0;
      case (ctl.link_we)
         flca_pkg::LW_VAL: begin
            link_we = 1'b1;
            link_waddr = sel_ff;
            link_wdata = val_ff;
         end
         flca_pkg::LW_TAIL: begin
            link_we = 1'b1;
            link_waddr = node_ff;
            link_wdata = pause_ff ? '0 : child_rd;
         end
         flca_pkg::LW_CLR: begin
            link_we = 1'b1;
            link_waddr = clr_ff;
         end
         default: link_we = 1'b0;
      endcase

      child_we = 1'b0;
      child_waddr = sel_ff;
      child_wdata = '0;
      case (ctl.child_we)
         flca_pkg::CW_VAL: begin
            child_we = 1'b1;
            child_wdata = val_ff;
         end
         flca_pkg::CW_PARENT: begin
            child_we = !pause_ff;
            child_wdata = head_ff;
         end
         flca_pkg::CW_CLR: begin
            child_we = 1'b1;
            child_waddr = clr_ff;
         end
         default: child_we = 1'b0;
      endcase
   end

   // datapath next values
   always_comb begin
      sel_in = sel_ff;
      val_in = val_ff;
      pause_in = pause_ff;
      count_in = count_ff;
      if (req_accept) begin
         sel_in = req_node_sel;
         val_in = req_write_value;
         pause_in = req_pause;
         if (req_alloc_count == '0) begin
            count_in = CW'(1);
         end else if (req_alloc_count > flca_pkg::MAX_ALLOC) begin
            count_in = flca_pkg::MAX_ALLOC;
         end else begin
            count_in = req_alloc_count;
         end
      end

      node_in = node_ff;
      head_in = head_ff;
      taken_in = taken_ff;
      if (ctl.load_node) begin
         node_in = free_head_ff;
         head_in = free_head_ff;
         taken_in = CW'(1);
      end else if (advance) begin
         node_in = link_rd;
         taken_in = taken_ff + CW'(1);
      end

      free_head_in = free_head_ff;
      if (ctl.fh == flca_pkg::FH_VAL) begin
         free_head_in = val_ff;
      end else if (ctl.fh == flca_pkg::FH_WALK && emit_fire && emit_last) begin
         free_head_in = link_rd;
      end

      clr_in = clr_ff;
      if (ctl.link_we == flca_pkg::LW_CLR) begin
         clr_in = clr_ff + NW'(1);
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = emit_fire || (rsp_valid_ff && rsp_stall);
      rsp_node_in = rsp_node_ff;
      rsp_taken_in = rsp_taken_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_last_in = rsp_last_ff;
      rsp_rlink_in = rsp_rlink_ff;
      rsp_rchild_in = rsp_rchild_ff;
      if (emit_fire) begin
         rsp_last_in = emit_last;
         rsp_rlink_in = '0;
         rsp_rchild_in = '0;
         rsp_empty_in = 1'b0;
         rsp_taken_in = '0;
         case (ctl.emit)
            flca_pkg::EM_ALLOC: begin
               rsp_node_in = node_ff;
               rsp_taken_in = taken_ff;
            end
            flca_pkg::EM_EMPTY: begin
               rsp_node_in = '0;
               rsp_empty_in = 1'b1;
            end
            default: begin
               rsp_node_in = sel_ff;
               rsp_rlink_in = link_rd;
               rsp_rchild_in = child_rd;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= '0;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         free_head_ff <= free_head_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      node_ff <= node_in;
      head_ff <= head_in;
      taken_ff <= taken_in;
      count_ff <= count_in;
      sel_ff <= sel_in;
      val_ff <= val_in;
      pause_ff <= pause_in;
      rsp_node_ff <= rsp_node_in;
      rsp_taken_ff <= rsp_taken_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_last_ff <= rsp_last_in;
      rsp_rlink_ff <= rsp_rlink_in;
      rsp_rchild_ff <= rsp_rchild_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_node_index = rsp_node_ff;
   assign rsp_taken_so_far = rsp_taken_ff;
   assign rsp_empty_res = rsp_empty_ff;
   assign rsp_last = rsp_last_ff;
   assign rsp_read_link = rsp_rlink_ff;
   assign rsp_read_child = rsp_rchild_ff;

`ifndef SYNTH
   a_empty_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> rsp_last && rsp_node_index == '0
         && rsp_taken_so_far == '0)
      else $error("empty beat malformed");

   a_taken_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_taken_so_far <= flca_pkg::MAX_ALLOC)
      else $error("taken count beyond limit");

   a_clear_blocks: assert property (@(posedge clock)
      $past(reset) |-> req_stall)
      else $error("request taken during clearing pass");

   a_walk_step: assert property (@(posedge clock) disable iff (reset)
      advance |=> taken_ff == $past(taken_ff) + CW'(1))
      else $error("walk count did not step");
`endif

endmodule
